>>> design/scwm_pkg.sv
// Shared types and constants for the stereo correlation and width meter.
// Used by every module of the block; no dependencies of its own.
package scwm_pkg;

   // Sample and accumulator sizing
   localparam int SAMPLE_BITS = 24;
   localparam int BLOCK_LOG   = 12;
   localparam int SQ_W        = 2 * SAMPLE_BITS - 2 + BLOCK_LOG;  // L*L and R*R sums
   localparam int MS_W        = SQ_W + 1;                         // mid and side sums
   localparam int CR_W        = SQ_W + 1;                         // signed cross sum
   localparam int PSQ_W       = 2 * SAMPLE_BITS - 1;              // one L*L product
   localparam int PCR_W       = 2 * SAMPLE_BITS;                  // one L*R product
   localparam int PMS_W       = 2 * SAMPLE_BITS;                  // one half mid square

   // Back end arithmetic
   localparam int ROOT_W  = 32;
   localparam int K_W     = 5;
   localparam int X_W     = 64;
   localparam int DIV_N_W = 64;
   localparam int DIV_D_W = 34;
   localparam int ST_W    = 32;
   localparam int ALPHA_W = 16;
   localparam logic [ALPHA_W-1:0] ALPHA_RESET = 16'd4500;
   localparam logic signed [ST_W-1:0] ONE_Q30 = 32'sh4000_0000;

   // Stream widths
   localparam int REQ_W   = 2 * SAMPLE_BITS;
   localparam int CORR_W  = 16;
   localparam int WIDTH_W = 15;
   localparam int BAL_W   = 16;
   localparam int RSP_W   = 48;

   // Block sums handed from the front to the back
   typedef struct packed {
      logic        [SQ_W-1:0] ll;
      logic        [SQ_W-1:0] rr;
      logic signed [CR_W-1:0] cr;
      logic        [MS_W-1:0] mm;
      logic        [MS_W-1:0] ss;
   } sums_type;

endpackage

>>> design/scwm_front.sv
// Front end: accepts samples, forms products, accumulates block sums.
// Depends on scwm_pkg; pushes finished block sums to scwm_queue.
module scwm_front (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_tvalid,
   output logic                                   req_tready,
   input  logic [scwm_pkg::REQ_W-1:0]             req_tdata,  // left_sample, right_sample
   input  logic                                   req_tlast,  // block_end
   output logic                                   q_push,
   output scwm_pkg::sums_type                     q_data,
   input  logic                                   q_ready
);

   localparam int SB = scwm_pkg::SAMPLE_BITS;

   logic signed [SB-1:0] l_s, r_s;
   logic signed [SB:0]   mid_s, side_s;
   logic signed [2*SB-1:0] sq_l, sq_r, cr_p;
   logic signed [2*SB+1:0] sq_m, sq_d;

   logic s1_valid_ff, s1_valid_in;
   logic s1_last_ff, s1_last_in;
   logic [scwm_pkg::PSQ_W-1:0] pll_ff, pll_in, prr_ff, prr_in;
   logic signed [scwm_pkg::PCR_W-1:0] plr_ff, plr_in;
   logic [scwm_pkg::PMS_W-1:0] pmm_ff, pmm_in, pss_ff, pss_in;
   logic s1_fire;

   scwm_pkg::sums_type acc_ff, acc_in, acc_next;

   logic [scwm_pkg::SQ_W:0]   ll_sum, rr_sum;
   logic [scwm_pkg::MS_W:0]   mm_sum, ss_sum;
   logic signed [scwm_pkg::CR_W:0] cr_sum;

   // Form the five products of one sample
   always_comb begin
      l_s    = req_tdata[SB-1:0];
      r_s    = req_tdata[2*SB-1:SB];
      mid_s  = {l_s[SB-1], l_s} + {r_s[SB-1], r_s};
      side_s = {l_s[SB-1], l_s} - {r_s[SB-1], r_s};
      sq_l   = l_s * l_s;
      sq_r   = r_s * r_s;
      cr_p   = l_s * r_s;
      sq_m   = mid_s * mid_s;
      sq_d   = side_s * side_s;
      pll_in = sq_l[scwm_pkg::PSQ_W-1:0];
      prr_in = sq_r[scwm_pkg::PSQ_W-1:0];
      plr_in = cr_p;
      pmm_in = sq_m[2*SB:1];
      pss_in = sq_d[2*SB:1];
   end

   // Advance the product stage unless a block end waits on a full queue
   assign s1_fire    = s1_valid_ff & (~s1_last_ff | q_ready);
   assign req_tready = ~s1_valid_ff | s1_fire;
   assign s1_valid_in = req_tready ? req_tvalid : s1_valid_ff;
   assign s1_last_in  = req_tready ? req_tlast : s1_last_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s1_last_ff  <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s1_last_ff  <= s1_last_in;
      end
      if (req_tready) begin
         pll_ff <= pll_in;
         prr_ff <= prr_in;
         plr_ff <= plr_in;
         pmm_ff <= pmm_in;
         pss_ff <= pss_in;
      end
   end

   // Saturating accumulation
   always_comb begin
      ll_sum = {1'b0, acc_ff.ll} + (scwm_pkg::SQ_W+1)'(pll_ff);
      rr_sum = {1'b0, acc_ff.rr} + (scwm_pkg::SQ_W+1)'(prr_ff);
      mm_sum = {1'b0, acc_ff.mm} + (scwm_pkg::MS_W+1)'(pmm_ff);
      ss_sum = {1'b0, acc_ff.ss} + (scwm_pkg::MS_W+1)'(pss_ff);
      cr_sum = {acc_ff.cr[scwm_pkg::CR_W-1], acc_ff.cr}
             + (scwm_pkg::CR_W+1)'(plr_ff);

      acc_next.ll = ll_sum[scwm_pkg::SQ_W] ? '1 : ll_sum[scwm_pkg::SQ_W-1:0];
      acc_next.rr = rr_sum[scwm_pkg::SQ_W] ? '1 : rr_sum[scwm_pkg::SQ_W-1:0];
      acc_next.mm = mm_sum[scwm_pkg::MS_W] ? '1 : mm_sum[scwm_pkg::MS_W-1:0];
      acc_next.ss = ss_sum[scwm_pkg::MS_W] ? '1 : ss_sum[scwm_pkg::MS_W-1:0];
      // clamp the cross sum to its signed range
      if (cr_sum[scwm_pkg::CR_W] != cr_sum[scwm_pkg::CR_W-1])
         acc_next.cr = cr_sum[scwm_pkg::CR_W]
                     ? {1'b1, {(scwm_pkg::CR_W-1){1'b0}}}
                     : {1'b0, {(scwm_pkg::CR_W-1){1'b1}}};
      else
         acc_next.cr = cr_sum[scwm_pkg::CR_W-1:0];

      acc_in = acc_ff;
      if (s1_fire)
         acc_in = s1_last_ff ? '0 : acc_next;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff <= '0;
      end else begin
         acc_ff <= acc_in;
      end
   end

   // Hand the finished block to the back end
   assign q_push = s1_fire & s1_last_ff;
   assign q_data = acc_next;

endmodule

>>> design/scwm_queue.sv
// Two-entry queue of block sums between the front and back ends.
// Depends on scwm_pkg for the sums record.
module scwm_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  scwm_pkg::sums_type push_data,
   output logic               push_ready,
   input  logic               pop,
   output logic               pop_valid,
   output scwm_pkg::sums_type pop_data
);

   scwm_pkg::sums_type mem_ff [2];
   logic       wr_ff, wr_in, rd_ff, rd_in;
   logic [1:0] cnt_ff, cnt_in;
   logic       do_push, do_pop;

   assign push_ready = (cnt_ff != 2'd2);
   assign pop_valid  = (cnt_ff != 2'd0);
   assign pop_data   = mem_ff[rd_ff];
   assign do_push    = push & push_ready;
   assign do_pop     = pop & pop_valid;

   // Advance pointers and count
   always_comb begin
      wr_in  = do_push ? ~wr_ff : wr_ff;
      rd_in  = do_pop ? ~rd_ff : rd_ff;
      cnt_in = cnt_ff + 2'(do_push) - 2'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= 1'b0;
         rd_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
      if (do_push)
         mem_ff[wr_ff] <= push_data;
   end

endmodule

>>> design/scwm_sqrt.sv
// Iterative square root: even normalize shift, then one result bit a cycle.
// Depends on scwm_pkg for widths.
module scwm_sqrt (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   input  logic [scwm_pkg::MS_W-1:0]      x,
   output logic                           done,
   output logic [scwm_pkg::ROOT_W-1:0]    root,
   output logic [scwm_pkg::K_W-1:0]       k
);

   typedef enum logic [2:0] {
      SQ_IDLE = 3'b001,
      SQ_NORM = 3'b010,
      SQ_ITER = 3'b100
   } sq_state_type;

   localparam logic [scwm_pkg::X_W-1:0] TOP_BIT = 64'h4000_0000_0000_0000;

   sq_state_type state_ff, state_in;
   logic [scwm_pkg::X_W-1:0] x_ff, x_in, res_ff, res_in, bit_ff, bit_in;
   logic [scwm_pkg::X_W-1:0] trial;
   logic [scwm_pkg::K_W-1:0] k_ff, k_in;
   logic done_ff, done_in;

   // One normalize or root step per cycle
   always_comb begin
      state_in = state_ff;
      x_in     = x_ff;
      res_in   = res_ff;
      bit_in   = bit_ff;
      k_in     = k_ff;
      done_in  = 1'b0;
      trial    = res_ff + bit_ff;
      case (state_ff)
         SQ_IDLE: begin
            if (start) begin
               x_in     = scwm_pkg::X_W'(x);
               k_in     = '0;
               res_in   = '0;
               state_in = SQ_NORM;
            end
         end
         SQ_NORM: begin
            if (x_ff == '0) begin
               done_in  = 1'b1;
               state_in = SQ_IDLE;
            end else if (x_ff[63:62] == 2'b00) begin
               x_in = {x_ff[61:0], 2'b00};
               k_in = k_ff + 1'b1;
            end else begin
               bit_in   = TOP_BIT;
               state_in = SQ_ITER;
            end
         end
         SQ_ITER: begin
            if (x_ff >= trial) begin
               x_in   = x_ff - trial;
               res_in = (res_ff >> 1) + bit_ff;
            end else begin
               res_in = res_ff >> 1;
            end
            bit_in = bit_ff >> 2;
            if (bit_ff[0]) begin
               done_in  = 1'b1;
               state_in = SQ_IDLE;
            end
         end
         default: state_in = SQ_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= SQ_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
      x_ff   <= x_in;
      res_ff <= res_in;
      bit_ff <= bit_in;
      k_ff   <= k_in;
   end

   assign done = done_ff;
   assign root = res_ff[scwm_pkg::ROOT_W-1:0];
   assign k    = k_ff;

endmodule

>>> design/scwm_div.sv
// Restoring divider, one quotient bit per cycle.
// Depends on scwm_pkg for widths.
module scwm_div (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   input  logic [scwm_pkg::DIV_N_W-1:0]    num,
   input  logic [scwm_pkg::DIV_D_W-1:0]    den,
   output logic                            done,
   output logic [scwm_pkg::DIV_N_W-1:0]    quo
);

   typedef enum logic [1:0] {
      DV_IDLE = 2'b01,
      DV_RUN  = 2'b10
   } dv_state_type;

   dv_state_type state_ff, state_in;
   logic [scwm_pkg::DIV_N_W-1:0] quo_ff, quo_in;
   logic [scwm_pkg::DIV_D_W-1:0] den_ff, den_in, rem_ff, rem_in;
   logic [scwm_pkg::DIV_D_W:0]   trial;
   logic [5:0] cnt_ff, cnt_in;
   logic done_ff, done_in;

   // Shift in one dividend bit and subtract when it fits
   always_comb begin
      state_in = state_ff;
      quo_in   = quo_ff;
      den_in   = den_ff;
      rem_in   = rem_ff;
      cnt_in   = cnt_ff;
      done_in  = 1'b0;
      trial    = {rem_ff, quo_ff[scwm_pkg::DIV_N_W-1]};
      case (state_ff)
         DV_IDLE: begin
            if (start) begin
               quo_in   = num;
               den_in   = den;
               rem_in   = '0;
               cnt_in   = '1;
               state_in = DV_RUN;
            end
         end
         DV_RUN: begin
            if (trial >= {1'b0, den_ff}) begin
               rem_in = scwm_pkg::DIV_D_W'(trial - {1'b0, den_ff});
               quo_in = {quo_ff[scwm_pkg::DIV_N_W-2:0], 1'b1};
            end else begin
               rem_in = trial[scwm_pkg::DIV_D_W-1:0];
               quo_in = {quo_ff[scwm_pkg::DIV_N_W-2:0], 1'b0};
            end
            cnt_in = cnt_ff - 1'b1;
            if (cnt_ff == '0) begin
               done_in  = 1'b1;
               state_in = DV_IDLE;
            end
         end
         default: state_in = DV_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= DV_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
      quo_ff <= quo_in;
      den_ff <= den_in;
      rem_ff <= rem_in;
      cnt_ff <= cnt_in;
   end

   assign done = done_ff;
   assign quo  = quo_ff;

endmodule

>>> design/scwm_back.sv
// Back end: roots, ratios, smoothing and the registered result of each block.
// Depends on scwm_pkg, scwm_sqrt and scwm_div.
module scwm_back (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               q_valid,
   input  scwm_pkg::sums_type                 q_data,
   output logic                               q_pop,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [scwm_pkg::ALPHA_W-1:0]       csr_data,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [scwm_pkg::RSP_W-1:0]         rsp_tdata   // correlation, stereo_width, balance
);

   typedef enum logic [11:0] {
      B_IDLE       = 12'b000000000001,
      B_ROOT       = 12'b000000000010,
      B_ROOT_WAIT  = 12'b000000000100,
      B_ALIGN      = 12'b000000001000,
      B_RATIO      = 12'b000000010000,
      B_RATIO_WAIT = 12'b000000100000,
      B_CMUL       = 12'b000001000000,
      B_CDIV       = 12'b000010000000,
      B_CDIV_WAIT  = 12'b000100000000,
      B_SMUL       = 12'b001000000000,
      B_SUPD       = 12'b010000000000,
      B_EMIT       = 12'b100000000000
   } back_state_type;

   localparam int RW = scwm_pkg::ROOT_W;
   localparam int KW = scwm_pkg::K_W;
   localparam int SW = scwm_pkg::ST_W;
   localparam int PW = SW + 1 + scwm_pkg::ALPHA_W + 1;

   back_state_type state_ff, state_in;
   scwm_pkg::sums_type sums_ff, sums_in;
   logic [RW-1:0] root_ff [4];
   logic [KW-1:0] kk_ff [4];
   logic [1:0]    idx_ff, idx_in;
   logic          pair_ff, pair_in;
   logic [RW-1:0] a_ff, a_in, b_ff, b_in;
   logic          neg_ff, neg_in;
   logic [RW-1:0] pd_ff, pd_in;
   logic [scwm_pkg::DIV_N_W-1:0] n_ff, n_in;
   logic signed [SW-1:0] blk_ff [3];
   logic signed [SW-1:0] st_ff [3];
   logic [1:0]    sidx_ff, sidx_in;
   logic signed [PW-1:0] p_ff, p_in;
   logic [scwm_pkg::ALPHA_W-1:0] alpha_ff;
   logic rsp_valid_ff, rsp_valid_in;
   logic [scwm_pkg::RSP_W-1:0] rsp_data_ff, rsp_data_in;
   logic load_out;

   // Shared unit handshakes
   logic sq_start, sq_done;
   logic [scwm_pkg::MS_W-1:0] sq_x;
   logic [RW-1:0] sq_root;
   logic [KW-1:0] sq_k;
   logic dv_start, dv_done;
   logic [scwm_pkg::DIV_N_W-1:0] dv_num, dv_quo;
   logic [scwm_pkg::DIV_D_W-1:0] dv_den;

   // Alignment and ratio terms
   logic [RW-1:0] sa, sb;
   logic [KW-1:0] ka, kb, km;
   logic [RW:0]   den_r;
   logic [RW-1:0] num_r;
   logic signed [SW-1:0] ratio_v;
   logic [scwm_pkg::X_W-1:0] c_mag, lim, n_c;
   logic [2*RW-1:0] prod_c;
   logic signed [KW+1:0] t_s;
   logic [5:0] t_neg;
   logic [SW-1:0] corr_q;
   logic signed [SW:0] diff_s;
   logic [PW-1:0] p_mag;
   logic [PW-16:0] p_q;
   logic signed [SW-1:0] st_new;
   logic signed [SW-1:0] st_sel, blk_sel;

   // Output rounding
   logic [SW-1:0] o_mag [3];
   logic [17:0]   o_q [3];
   logic signed [18:0] o_v [3];
   logic signed [18:0] o_c [3];

   scwm_sqrt u_sqrt (
      .clock (clock),
      .reset (reset),
      .start (sq_start),
      .x     (sq_x),
      .done  (sq_done),
      .root  (sq_root),
      .k     (sq_k)
   );

   scwm_div u_div (
      .clock (clock),
      .reset (reset),
      .start (dv_start),
      .num   (dv_num),
      .den   (dv_den),
      .done  (dv_done),
      .quo   (dv_quo)
   );

   // Pick the sum whose root is next
   always_comb begin
      case (idx_ff)
         2'd0:    sq_x = sums_ff.mm;
         2'd1:    sq_x = sums_ff.ss;
         2'd2:    sq_x = scwm_pkg::MS_W'(sums_ff.ll);
         default: sq_x = scwm_pkg::MS_W'(sums_ff.rr);
      endcase
   end

   // Bring a pair of roots to a common scale
   always_comb begin
      sa = root_ff[{pair_ff, 1'b0}];
      sb = root_ff[{pair_ff, 1'b1}];
      ka = kk_ff[{pair_ff, 1'b0}];
      kb = kk_ff[{pair_ff, 1'b1}];
      if (sa == '0) ka = kb;
      if (sb == '0) kb = ka;
      km = (ka < kb) ? ka : kb;
      a_in = sa >> (ka - km);
      b_in = sb >> (kb - km);
   end

   // Width and balance ratio terms
   always_comb begin
      den_r = {1'b0, a_ff} + {1'b0, b_ff};
      if (!pair_ff)
         num_r = b_ff;
      else
         num_r = (b_ff >= a_ff) ? b_ff - a_ff : a_ff - b_ff;
      ratio_v = $signed({1'b0, dv_quo[SW-2:0]});
   end

   // Correlation numerator and denominator
   always_comb begin
      c_mag  = sums_ff.cr[scwm_pkg::CR_W-1]
             ? scwm_pkg::X_W'(-$signed({sums_ff.cr[scwm_pkg::CR_W-1], sums_ff.cr}))
             : scwm_pkg::X_W'(sums_ff.cr);
      t_s    = $signed({2'b00, kk_ff[2]}) + $signed({2'b00, kk_ff[3]}) - 7'sd2;
      t_neg  = 6'(-t_s);
      lim    = 64'h4000_0000_0000_0000 >> t_s[5:0];
      if (!t_s[KW+1])
         n_c = (c_mag > lim) ? 64'h4000_0000_0000_0000 : (c_mag << t_s[5:0]);
      else
         n_c = c_mag >> t_neg;
      prod_c = root_ff[2] * root_ff[3];
      pd_in  = prod_c[2*RW-1:RW];
      n_in   = n_c;
      corr_q = (dv_quo > scwm_pkg::DIV_N_W'(scwm_pkg::ONE_Q30))
             ? scwm_pkg::ONE_Q30 : dv_quo[SW-1:0];
   end

   // One-pole smoothing terms
   always_comb begin
      st_sel  = st_ff[sidx_ff];
      blk_sel = blk_ff[sidx_ff];
      diff_s  = {blk_sel[SW-1], blk_sel} - {st_sel[SW-1], st_sel};
      p_in    = diff_s * $signed({1'b0, alpha_ff});
      p_mag   = p_ff[PW-1] ? PW'(-p_ff) : PW'(p_ff);
      p_q     = (PW-15)'((p_mag + PW'(32768)) >> 16);
      st_new  = p_ff[PW-1] ? st_sel - SW'(p_q) : st_sel + SW'(p_q);
   end

   // Round the smoothed state to Q1.15 and saturate
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         o_mag[i] = st_ff[i][SW-1] ? SW'(-st_ff[i]) : SW'(st_ff[i]);
         o_q[i]   = 18'(({1'b0, o_mag[i]} + 33'd16384) >> 15);
         o_v[i]   = st_ff[i][SW-1] ? -$signed({1'b0, o_q[i]}) : $signed({1'b0, o_q[i]});
         o_c[i]   = o_v[i];
         if (o_v[i] > 19'sd32767) o_c[i] = 19'sd32767;
      end
      if (o_v[0] < -19'sd32768) o_c[0] = -19'sd32768;
      if (o_v[1] < 19'sd0)      o_c[1] = 19'sd0;
      if (o_v[2] < -19'sd32768) o_c[2] = -19'sd32768;
      rsp_data_in = {1'b0, o_c[2][scwm_pkg::BAL_W-1:0],
                     o_c[1][scwm_pkg::WIDTH_W-1:0], o_c[0][scwm_pkg::CORR_W-1:0]};
   end

   // Sequencer
   always_comb begin
      state_in = state_ff;
      sums_in  = sums_ff;
      idx_in   = idx_ff;
      pair_in  = pair_ff;
      neg_in   = neg_ff;
      sidx_in  = sidx_ff;
      q_pop    = 1'b0;
      sq_start = 1'b0;
      dv_start = 1'b0;
      dv_num   = n_ff + scwm_pkg::DIV_N_W'(pd_ff >> 1);
      dv_den   = scwm_pkg::DIV_D_W'(pd_ff);
      load_out = 1'b0;
      case (state_ff)
         B_IDLE: begin
            if (q_valid) begin
               q_pop    = 1'b1;
               sums_in  = q_data;
               idx_in   = 2'd0;
               state_in = B_ROOT;
            end
         end
         B_ROOT: begin
            sq_start = 1'b1;
            state_in = B_ROOT_WAIT;
         end
         B_ROOT_WAIT: begin
            if (sq_done) begin
               idx_in = idx_ff + 1'b1;
               if (idx_ff == 2'd3) begin
                  pair_in  = 1'b0;
                  state_in = B_ALIGN;
               end else begin
                  state_in = B_ROOT;
               end
            end
         end
         B_ALIGN: state_in = B_RATIO;
         B_RATIO: begin
            dv_num = (scwm_pkg::DIV_N_W'(num_r) << 30) + scwm_pkg::DIV_N_W'(den_r >> 1);
            dv_den = scwm_pkg::DIV_D_W'(den_r);
            neg_in = pair_ff & (b_ff < a_ff);
            if (den_r == '0) begin
               pair_in  = 1'b1;
               state_in = pair_ff ? B_CMUL : B_ALIGN;
            end else begin
               dv_start = 1'b1;
               state_in = B_RATIO_WAIT;
            end
         end
         B_RATIO_WAIT: begin
            if (dv_done) begin
               pair_in  = 1'b1;
               state_in = pair_ff ? B_CMUL : B_ALIGN;
            end
         end
         B_CMUL: begin
            if (root_ff[2] == '0 || root_ff[3] == '0) begin
               sidx_in  = 2'd0;
               state_in = B_SMUL;
            end else begin
               state_in = B_CDIV;
            end
         end
         B_CDIV: begin
            dv_start = 1'b1;
            state_in = B_CDIV_WAIT;
         end
         B_CDIV_WAIT: begin
            if (dv_done) begin
               sidx_in  = 2'd0;
               state_in = B_SMUL;
            end
         end
         B_SMUL: state_in = B_SUPD;
         B_SUPD: begin
            sidx_in = sidx_ff + 1'b1;
            state_in = (sidx_ff == 2'd2) ? B_EMIT : B_SMUL;
         end
         B_EMIT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               load_out = 1'b1;
               state_in = B_IDLE;
            end
         end
         default: state_in = B_IDLE;
      endcase
      rsp_valid_in = load_out | (rsp_valid_ff & ~rsp_tready);
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= B_IDLE;
         rsp_valid_ff <= 1'b0;
         alpha_ff     <= scwm_pkg::ALPHA_RESET;
         st_ff[0]     <= scwm_pkg::ONE_Q30;
         st_ff[1]     <= '0;
         st_ff[2]     <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid)
            alpha_ff <= csr_data;
         if (state_ff == B_SUPD)
            st_ff[sidx_ff] <= st_new;
      end
   end

   // Datapath registers
   always_ff @(posedge clock) begin
      sums_ff <= sums_in;
      idx_ff  <= idx_in;
      pair_ff <= pair_in;
      neg_ff  <= neg_in;
      sidx_ff <= sidx_in;
      p_ff    <= p_in;
      if (state_ff == B_ROOT_WAIT && sq_done) begin
         root_ff[idx_ff] <= sq_root;
         kk_ff[idx_ff]   <= sq_k;
      end
      if (state_ff == B_ALIGN) begin
         a_ff <= a_in;
         b_ff <= b_in;
      end
      if (state_ff == B_CMUL) begin
         pd_ff <= pd_in;
         n_ff  <= n_in;
      end
      if (state_ff == B_RATIO && den_r == '0)
         blk_ff[{1'b0, pair_ff} + 2'd1] <= '0;
      if (state_ff == B_RATIO_WAIT && dv_done)
         blk_ff[{1'b0, pair_ff} + 2'd1] <= neg_ff ? -ratio_v : ratio_v;
      if (state_ff == B_CMUL && (root_ff[2] == '0 || root_ff[3] == '0))
         blk_ff[0] <= scwm_pkg::ONE_Q30;
      if (state_ff == B_CDIV_WAIT && dv_done)
         blk_ff[0] <= sums_ff.cr[scwm_pkg::CR_W-1] ? -$signed(corr_q) : $signed(corr_q);
      if (load_out)
         rsp_data_ff <= rsp_data_in;
   end

   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

>>> design/stereo_correlation_width_meter.sv
// Stereo correlation, width and balance meter, top level.
// Samples: one transfer per cycle unless a block end waits on a full queue; each
// sample's products are registered before joining the block sums. A block end's result
// takes four roots on the shared root unit and up to three divides on the shared divider.
// Two finished blocks may wait between the front and the back before input stalls.
// Sync reset: sums clear, smoothed state to 1,0,0, alpha to 4500; no clearing pass.
module stereo_correlation_width_meter (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [scwm_pkg::REQ_W-1:0]        req_tdata,   // left_sample, right_sample
   input  logic                              req_tlast,   // block_end
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [scwm_pkg::ALPHA_W-1:0]      csr_data,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [scwm_pkg::RSP_W-1:0]        rsp_tdata    // correlation, stereo_width, balance
);

   logic               push, push_ready, pop, pop_valid;
   scwm_pkg::sums_type push_data, pop_data;

   scwm_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .q_push     (push),
      .q_data     (push_data),
      .q_ready    (push_ready)
   );

   scwm_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_data  (push_data),
      .push_ready (push_ready),
      .pop        (pop),
      .pop_valid  (pop_valid),
      .pop_data   (pop_data)
   );

   scwm_back u_back (
      .clock      (clock),
      .reset      (reset),
      .q_valid    (pop_valid),
      .q_data     (pop_data),
      .q_pop      (pop),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule
